// File: hw/rtl/pmpa_pkg.sv
package pmpa_pkg;

    // defaults of the top level parameters
    localparam int MAX_DIM_DEF       = 4096;
    localparam int CORDIC_STAGES_DEF = 16;

    // datapath widths
    localparam int XW    = 44;   // CORDIC x/y
    localparam int ZW    = 34;   // CORDIC angle accumulator
    localparam int AW    = 35;   // pixel offset from focus
    localparam int MW    = 36;   // frame multiplier operands
    localparam int NUMW  = 56;   // dividend magnitude
    localparam int NORM_TOP = 40; // vectors are scaled until max(|x|,|y|) >= 2^40

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam int          CORDIC_X0    = 652032874;
    localparam logic [33:0] TILT_TO_TURN = 34'd5468522205;
    localparam logic [15:0] DEG_FULL     = 16'd46080;

    // input item kinds
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_FOCAL  = 3'd0;
    localparam logic [2:0] REG_PRIN_X = 3'd1;
    localparam logic [2:0] REG_PRIN_Y = 3'd2;
    localparam logic [2:0] REG_DELTA_X = 3'd3;
    localparam logic [2:0] REG_DELTA_Y = 3'd4;
    localparam logic [2:0] REG_DELTA_Z = 3'd5;
    localparam logic [2:0] REG_TILT_X = 3'd6;
    localparam logic [2:0] REG_TILT_Y = 3'd7;

    typedef struct packed {
        logic        [19:0] focal;
        logic        [15:0] prin_x;
        logic        [15:0] prin_y;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
    } t_cfg;

    // per-item side info riding along the pixel pipeline
    typedef struct packed {
        logic        zero;
        logic        lat;
        logic [15:0] lat_ang;
    } t_side;

    // frame result handed to the top level
    typedef struct packed {
        logic               lateral;
        logic        [15:0] lat_ang;
        logic signed [31:0] focus_x;
        logic signed [31:0] focus_y;
    } t_fupd;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // binary angle to Q9.7 degrees, rounded, full turn folds to zero
    function automatic logic [15:0] turn_to_deg(input logic [31:0] t);
        logic [47:0] p;
        logic [15:0] v;
        p = {16'b0, t} * {32'b0, DEG_FULL} + 48'h0000_8000_0000;
        v = p[47:32];
        return (v >= DEG_FULL) ? 16'd0 : v;
    endfunction

endpackage

// File: hw/rtl/pmpa_cell.sv
// One vectoring CORDIC cell: rotates toward the x axis by atan(2^-STAGE).
module pmpa_cell #(
    parameter int STAGE = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [pmpa_pkg::XW-1:0]  i_x,
    input  logic signed [pmpa_pkg::XW-1:0]  i_y,
    input  logic        [31:0]              i_acc,
    input  pmpa_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic signed [pmpa_pkg::XW-1:0]  o_x,
    output logic signed [pmpa_pkg::XW-1:0]  o_y,
    output logic        [31:0]              o_acc,
    output pmpa_pkg::t_side                 o_side
);

    logic signed [pmpa_pkg::XW-1:0] n_x;
    logic signed [pmpa_pkg::XW-1:0] n_y;
    logic        [31:0]             n_acc;

    // micro-rotation
    always_comb begin
        if (i_y > 0) begin
            n_x   = i_x + (i_y >>> STAGE);
            n_y   = i_y - (i_x >>> STAGE);
            n_acc = i_acc + pmpa_pkg::atan_turn(STAGE);
        end else begin
            n_x   = i_x - (i_y >>> STAGE);
            n_y   = i_y + (i_x >>> STAGE);
            n_acc = i_acc - pmpa_pkg::atan_turn(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_acc  <= n_acc;
            o_side <= i_side;
        end
    end

endmodule

// File: hw/rtl/pmpa_frame.sv
// Frame-start sequencer: tilt sin/cos, rotated translation, focus by
// restoring division, or the lateral angle when forward motion is zero.
module pmpa_frame #(
    parameter int CORDIC_STAGES = pmpa_pkg::CORDIC_STAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pmpa_pkg::t_cfg   i_cfg,
    output logic             o_busy,
    output logic             o_done,
    output pmpa_pkg::t_fupd  o_upd
);

    localparam int XW   = pmpa_pkg::XW;
    localparam int ZW   = pmpa_pkg::ZW;
    localparam int MW   = pmpa_pkg::MW;
    localparam int NUMW = pmpa_pkg::NUMW;
    localparam int IW   = $clog2(CORDIC_STAGES);
    localparam int CW   = $clog2(NUMW);

    typedef enum logic [3:0] {
        F_IDLE, F_TILT, F_ROT, F_SC, F_PMUL, F_PACC, F_CHK,
        F_NORM, F_VEC, F_LAT, F_FMUL, F_DIV, F_FIN
    } t_fstate;

    t_fstate                 r_st;
    pmpa_pkg::t_cfg          r_cfg;
    logic                    r_axis;
    logic [IW-1:0]           r_i;
    logic signed [XW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic                    r_flip;
    logic signed [MW-1:0]    r_cx, r_sx, r_cy, r_sy;
    logic [3:0]              r_step;
    logic signed [MW-1:0]    r_prod, r_tmp;
    logic signed [MW-1:0]    r_dx, r_dy, r_dz;
    logic [NUMW-1:0]         r_num;
    logic [MW-1:0]           r_den;
    logic [MW-1:0]           r_rem;
    logic                    r_neg;
    logic [CW-1:0]           r_cnt;

    // shared multiplier
    logic signed [MW-1:0]    w_ma, w_mb;
    logic signed [2*MW-1:0]  w_mp;
    logic signed [MW-1:0]    w_xd, w_yd, w_zd;
    logic signed [15:0]      w_tilt;

    // CORDIC step, rotation or vectoring
    logic                    w_pos;
    logic signed [XW-1:0]    w_sx, w_sy;
    logic signed [ZW-1:0]    w_sz;
    logic [ZW-1:0]           w_at;

    logic [47:0]             w_tp;
    logic [31:0]             w_turn, w_turn_f;
    logic                    w_flip;
    logic [XW-1:0]           w_ay, w_m;
    logic signed [NUMW:0]    w_num;
    logic [MW:0]             w_rsh;
    logic                    w_ge;
    logic signed [NUMW:0]    w_q;
    logic signed [NUMW+1:0]  w_sum;
    logic signed [31:0]      w_sat;
    logic [15:0]             w_prin;
    logic signed [XW-1:0]    w_cos, w_sin;

    assign w_xd   = -MW'(r_cfg.delta_x);
    assign w_yd   = -MW'(r_cfg.delta_y);
    assign w_zd   = MW'(r_cfg.delta_z);
    assign w_tilt = r_axis ? r_cfg.tilt_y : r_cfg.tilt_x;

    // operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            F_TILT: begin
                w_ma = MW'(w_tilt);
                w_mb = MW'(signed'({1'b0, pmpa_pkg::TILT_TO_TURN}));
            end
            F_PMUL: begin
                case (r_step)
                    4'd0:  begin w_ma = r_cy;  w_mb = w_xd; end
                    4'd1:  begin w_ma = r_sy;  w_mb = w_zd; end
                    4'd2:  begin w_ma = r_sx;  w_mb = r_sy; end
                    4'd3:  begin w_ma = r_tmp; w_mb = w_xd; end
                    4'd4:  begin w_ma = r_cx;  w_mb = w_yd; end
                    4'd5:  begin w_ma = r_sx;  w_mb = r_cy; end
                    4'd6:  begin w_ma = r_tmp; w_mb = w_zd; end
                    4'd7:  begin w_ma = r_cx;  w_mb = r_sy; end
                    4'd8:  begin w_ma = r_tmp; w_mb = w_xd; end
                    4'd9:  begin w_ma = r_sx;  w_mb = w_yd; end
                    4'd10: begin w_ma = r_cx;  w_mb = r_cy; end
                    4'd11: begin w_ma = r_tmp; w_mb = w_zd; end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            F_FMUL: begin
                w_ma = MW'(signed'({1'b0, r_cfg.focal}));
                w_mb = r_axis ? r_dy : r_dx;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp = w_ma * w_mb;

    // tilt to binary angle, folded into the right half plane
    always_comb begin
        w_tp     = w_mp[47:0] + 48'h8000;
        w_turn   = w_tp[47:16];
        w_flip   = 1'((w_turn + pmpa_pkg::QUARTER_TURN) >> 31);
        w_turn_f = w_flip ? (w_turn + pmpa_pkg::HALF_TURN) : w_turn;
    end

    always_comb begin
        w_pos = (r_st == F_ROT) ? (r_z >= 0) : !(r_y > 0);
        w_at  = ZW'(pmpa_pkg::atan_turn(int'(r_i)));
        if (w_pos) begin
            w_sx = r_x - (r_y >>> r_i);
            w_sy = r_y + (r_x >>> r_i);
            w_sz = r_z - signed'(w_at);
        end else begin
            w_sx = r_x + (r_y >>> r_i);
            w_sy = r_y - (r_x >>> r_i);
            w_sz = r_z + signed'(w_at);
        end
    end

    assign w_cos = r_flip ? -r_x : r_x;
    assign w_sin = r_flip ? -r_y : r_y;

    // normalize test for the lateral vector
    always_comb begin
        w_ay = (r_y < 0) ? XW'(-r_y) : XW'(r_y);
        w_m  = (XW'(r_x) > w_ay) ? XW'(r_x) : w_ay;
    end

    // divider step and final sum
    always_comb begin
        w_num  = w_mp[NUMW:0];
        w_rsh  = {r_rem, r_num[NUMW-1]};
        w_ge   = (w_rsh >= {1'b0, r_den});
        w_q    = r_neg ? -signed'({1'b0, r_num}) : signed'({1'b0, r_num});
        w_prin = r_axis ? r_cfg.prin_y : r_cfg.prin_x;
        w_sum  = (NUMW+2)'(w_q) + (NUMW+2)'(signed'({1'b0, w_prin}));
        if (w_sum > (NUMW+2)'(32'sh7FFF_FFFF)) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_sum < -(NUMW+2)'(33'sh0_8000_0000)) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign o_busy = (r_st != F_IDLE) || o_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= F_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_st)
                F_IDLE: begin
                    if (i_start) begin
                        r_cfg  <= i_cfg;
                        r_axis <= 1'b0;
                        r_st   <= F_TILT;
                    end
                end
                F_TILT: begin
                    r_flip <= w_flip;
                    r_z    <= ZW'(signed'(w_turn_f));
                    r_x    <= XW'(pmpa_pkg::CORDIC_X0);
                    r_y    <= '0;
                    r_i    <= '0;
                    r_st   <= F_ROT;
                end
                F_ROT: begin
                    r_x <= w_sx;
                    r_y <= w_sy;
                    r_z <= w_sz;
                    r_i <= r_i + 1'b1;
                    if (r_i == IW'(CORDIC_STAGES - 1)) begin
                        r_st <= F_SC;
                    end
                end
                F_SC: begin
                    if (!r_axis) begin
                        r_cx   <= MW'(w_cos);
                        r_sx   <= MW'(w_sin);
                        r_axis <= 1'b1;
                        r_st   <= F_TILT;
                    end else begin
                        r_cy   <= MW'(w_cos);
                        r_sy   <= MW'(w_sin);
                        r_step <= '0;
                        r_dx   <= '0;
                        r_dy   <= '0;
                        r_dz   <= '0;
                        r_st   <= F_PMUL;
                    end
                end
                F_PMUL: begin
                    r_prod <= MW'(w_mp >>> 30);
                    r_st   <= F_PACC;
                end
                F_PACC: begin
                    case (r_step)
                        4'd0:  r_dx  <= r_dx + r_prod;
                        4'd1:  r_dx  <= r_dx - r_prod;
                        4'd3:  r_dy  <= r_dy - r_prod;
                        4'd4:  r_dy  <= r_dy + r_prod;
                        4'd6:  r_dy  <= r_dy - r_prod;
                        4'd8:  r_dz  <= r_dz + r_prod;
                        4'd9:  r_dz  <= r_dz + r_prod;
                        4'd11: r_dz  <= r_dz + r_prod;
                        default: r_tmp <= r_prod;
                    endcase
                    r_step <= r_step + 1'b1;
                    r_st   <= (r_step == 4'd11) ? F_CHK : F_PMUL;
                end
                F_CHK: begin
                    r_axis <= 1'b0;
                    if (r_dz == 0) begin
                        if (r_dx == 0 && r_dy == 0) begin
                            r_z  <= '0;
                            r_st <= F_LAT;
                        end else begin
                            r_x  <= (r_dx < 0) ? -XW'(r_dx) : XW'(r_dx);
                            r_y  <= (r_dx < 0) ? -XW'(r_dy) : XW'(r_dy);
                            r_z  <= (r_dx < 0) ? ZW'(pmpa_pkg::HALF_TURN) : '0;
                            r_st <= F_NORM;
                        end
                    end else begin
                        r_st <= F_FMUL;
                    end
                end
                F_NORM: begin
                    if (w_m < (XW'(1) << pmpa_pkg::NORM_TOP)) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_i  <= '0;
                        r_st <= F_VEC;
                    end
                end
                F_VEC: begin
                    r_x <= w_sx;
                    r_y <= w_sy;
                    r_z <= w_sz;
                    r_i <= r_i + 1'b1;
                    if (r_i == IW'(CORDIC_STAGES - 1)) begin
                        r_st <= F_LAT;
                    end
                end
                F_LAT: begin
                    o_upd.lateral <= 1'b1;
                    o_upd.lat_ang <= pmpa_pkg::turn_to_deg(r_z[31:0]);
                    o_done        <= 1'b1;
                    r_st          <= F_IDLE;
                end
                F_FMUL: begin
                    r_neg <= (w_num < 0) ^ (r_dz < 0);
                    r_num <= (w_num < 0) ? NUMW'(-w_num) : NUMW'(w_num);
                    r_den <= (r_dz < 0) ? MW'(-r_dz) : MW'(r_dz);
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_st  <= F_DIV;
                end
                F_DIV: begin
                    r_rem <= w_ge ? MW'(w_rsh - {1'b0, r_den}) : w_rsh[MW-1:0];
                    r_num <= {r_num[NUMW-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NUMW - 1)) begin
                        r_st <= F_FIN;
                    end
                end
                F_FIN: begin
                    if (!r_axis) begin
                        o_upd.focus_x <= w_sat;
                        r_axis        <= 1'b1;
                        r_st          <= F_FMUL;
                    end else begin
                        o_upd.focus_y <= w_sat;
                        o_upd.lateral <= 1'b0;
                        o_done        <= 1'b1;
                        r_st          <= F_IDLE;
                    end
                end
                default: r_st <= F_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/pose_motion_pixel_angle.sv
// Channel   Dir  tvalid/tready       Payload
// input     in   i_s_tvalid/o_s_tready tdata: row[11:0] col[23:12]; tuser: op
// result    out  o_m_tvalid/i_m_tready tdata: angle[15:0]; tuser: lateral
// config    in   i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// Pixel items: one per clock while the result is taken and no frame start is
// being worked on; they pass stages A, B and C, the row of CORDIC cells and
// the output register. A frame-start item holds the input until the sequencer
// is done (focus by bit-serial divider, or lateral angle by shared CORDIC step).
// Reset is synchronous, active low; no clearing pass. A stalled result
// stalls the whole pipeline; pixels in flight keep the focus they entered with.
module pose_motion_pixel_angle #(
    parameter int MAX_DIM       = pmpa_pkg::MAX_DIM_DEF,
    parameter int CORDIC_STAGES = pmpa_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // row[11:0], col[23:12]
    input  logic [0:0]  i_s_tuser,   // op[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // angle[15:0]
    output logic [0:0]  o_m_tuser,   // lateral[0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    localparam int XW = pmpa_pkg::XW;
    localparam int AW = pmpa_pkg::AW;

    pmpa_pkg::t_cfg   r_cfg;
    logic signed [31:0] r_focus_x, r_focus_y;
    logic             r_is_lat;
    logic [15:0]      r_lat_ang;

    logic             w_en, w_acc, w_fbusy, w_fdone, w_inr;
    pmpa_pkg::t_fupd  w_fupd;
    logic [11:0]      w_row, w_col;

    assign w_row = i_s_tdata[11:0];
    assign w_col = i_s_tdata[23:12];
    assign w_en  = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en && !w_fbusy;
    assign w_acc = i_s_tvalid && o_s_tready;
    assign w_inr = (32'(w_row) < 32'(MAX_DIM)) && (32'(w_col) < 32'(MAX_DIM));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal   <= 20'd8000;
            r_cfg.prin_x  <= 16'd5120;
            r_cfg.prin_y  <= 16'd3840;
            r_cfg.delta_x <= '0;
            r_cfg.delta_y <= '0;
            r_cfg.delta_z <= '0;
            r_cfg.tilt_x  <= '0;
            r_cfg.tilt_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pmpa_pkg::REG_FOCAL:   r_cfg.focal   <= i_cfg_wdata[19:0];
                pmpa_pkg::REG_PRIN_X:  r_cfg.prin_x  <= i_cfg_wdata[15:0];
                pmpa_pkg::REG_PRIN_Y:  r_cfg.prin_y  <= i_cfg_wdata[15:0];
                pmpa_pkg::REG_DELTA_X: r_cfg.delta_x <= i_cfg_wdata;
                pmpa_pkg::REG_DELTA_Y: r_cfg.delta_y <= i_cfg_wdata;
                pmpa_pkg::REG_DELTA_Z: r_cfg.delta_z <= i_cfg_wdata;
                pmpa_pkg::REG_TILT_X:  r_cfg.tilt_x  <= i_cfg_wdata[15:0];
                pmpa_pkg::REG_TILT_Y:  r_cfg.tilt_y  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    pmpa_frame #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc && (i_s_tuser[0] == pmpa_pkg::OP_FRAME)),
        .i_cfg   (r_cfg),
        .o_busy  (w_fbusy),
        .o_done  (w_fdone),
        .o_upd   (w_fupd)
    );

    // focus state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_x <= '0;
            r_focus_y <= '0;
            r_is_lat  <= 1'b0;
            r_lat_ang <= '0;
        end else if (w_fdone) begin
            r_is_lat <= w_fupd.lateral;
            if (w_fupd.lateral) begin
                r_lat_ang <= w_fupd.lat_ang;
            end else begin
                r_focus_x <= w_fupd.focus_x;
                r_focus_y <= w_fupd.focus_y;
            end
        end
    end

    // stage A: offsets from the focus
    logic                 r_a_valid;
    logic signed [AW-1:0] r_a_x, r_a_y;
    pmpa_pkg::t_side      r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_acc && (i_s_tuser[0] == pmpa_pkg::OP_PIXEL) && w_inr;
        end
        if (w_en) begin
            r_a_x <= AW'(signed'({1'b0, w_col, 4'b0})) - AW'(r_focus_x);
            r_a_y <= AW'(signed'({1'b0, w_row, 4'b0})) - AW'(r_focus_y);
            r_a_side.zero    <= 1'b0;
            r_a_side.lat     <= r_is_lat;
            r_a_side.lat_ang <= r_lat_ang;
        end
    end

    // stage B: fold to right half plane, find normalizing shift
    logic                 r_b_valid;
    logic signed [AW-1:0] r_b_x, r_b_y;
    logic [31:0]          r_b_acc;
    logic [5:0]           r_b_sh;
    pmpa_pkg::t_side      r_b_side;
    logic signed [AW-1:0] w_bx, w_by;
    logic [AW-1:0]        w_bay, w_bm;
    logic [5:0]           w_msb;

    always_comb begin
        w_bx  = (r_a_x < 0) ? -r_a_x : r_a_x;
        w_by  = (r_a_x < 0) ? -r_a_y : r_a_y;
        w_bay = (w_by < 0) ? AW'(-w_by) : AW'(w_by);
        w_bm  = (AW'(w_bx) > w_bay) ? AW'(w_bx) : w_bay;
        w_msb = '0;
        for (int k = 0; k < AW; k++) begin
            if (w_bm[k]) begin
                w_msb = 6'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
        if (w_en) begin
            r_b_x    <= w_bx;
            r_b_y    <= w_by;
            r_b_acc  <= (r_a_x < 0) ? pmpa_pkg::HALF_TURN : 32'd0;
            r_b_sh   <= 6'(pmpa_pkg::NORM_TOP) - w_msb;
            r_b_side <= '{zero: (r_a_x == 0 && r_a_y == 0),
                          lat: r_a_side.lat, lat_ang: r_a_side.lat_ang};
        end
    end

    // stage C: scale up, feeds the cell row
    logic                 c_valid [CORDIC_STAGES+1];
    logic signed [XW-1:0] c_x     [CORDIC_STAGES+1];
    logic signed [XW-1:0] c_y     [CORDIC_STAGES+1];
    logic [31:0]          c_acc   [CORDIC_STAGES+1];
    pmpa_pkg::t_side      c_side  [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_valid[0] <= 1'b0;
        end else if (w_en) begin
            c_valid[0] <= r_b_valid;
        end
        if (w_en) begin
            c_x[0]    <= XW'(r_b_x) <<< r_b_sh;
            c_y[0]    <= XW'(r_b_y) <<< r_b_sh;
            c_acc[0]  <= r_b_acc;
            c_side[0] <= r_b_side;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pmpa_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_valid[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_acc   (c_acc[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_acc   (c_acc[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // output register: degrees or the lateral angle
    logic [31:0] w_turn;
    assign w_turn = c_side[CORDIC_STAGES].zero ? 32'd0 : c_acc[CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_en) begin
            o_m_tvalid <= c_valid[CORDIC_STAGES];
        end
        if (w_en) begin
            o_m_tdata <= c_side[CORDIC_STAGES].lat ? c_side[CORDIC_STAGES].lat_ang
                                                   : pmpa_pkg::turn_to_deg(w_turn);
            o_m_tuser <= c_side[CORDIC_STAGES].lat;
        end
    end

    // checks
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fbusy |-> !o_s_tready)
        else $error("input taken while frame sequencer busy");

    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_s_tuser[0] == pmpa_pkg::OP_FRAME)) |=> w_fbusy)
        else $error("frame start did not start the sequencer");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata < pmpa_pkg::DEG_FULL))
        else $error("angle out of range");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int STAGES   = pmpa_pkg::CORDIC_STAGES_DEF;
    localparam int DRAIN    = 2 * (STAGES + 3) + 26 + 2 * (pmpa_pkg::NUMW + 2) + STAGES + 40;
    localparam int MAX_CYC  = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;  // row[11:0], col[23:12]
    logic [0:0]  i_s_tuser = '0;  // op[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;       // angle[15:0]
    logic [0:0]  o_m_tuser;       // lateral[0]
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;

    pose_motion_pixel_angle dut (.*);

    always #5 i_clk = ~i_clk;

    // expected direction results, {lateral, angle}
    logic [16:0] angle_q[$];
    int          n_fail = 0;
    int          n_pix = 0;
    int          n_frame = 0;
    int          n_lat = 0;
    int          n_cyc = 0;
    int          rdy_hold = 0;
    bit          calm = 1'b0;   // no idling in the last part

    // predictor copy of registers and state
    logic [31:0] cfg_reg[8];
    logic signed [31:0] foe_x, foe_y;
    logic        lat_mode;
    logic [15:0] lat_deg;

    function automatic longint sx(logic [31:0] v, int w);
        longint m;
        m = longint'(1) << (w - 1);
        return (longint'(v & ((m << 1) - 1)) ^ m) - m;
    endfunction

    function automatic longint q30(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic void cordic_rot(logic [31:0] ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        logic [31:0] t;
        x = pmpa_pkg::CORDIC_X0; y = 0; flip = 0;
        t = ang + pmpa_pkg::QUARTER_TURN;
        if (t[31]) begin
            ang = ang + pmpa_pkg::HALF_TURN;
            flip = 1;
        end
        z = longint'(ang);
        if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(pmpa_pkg::atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(pmpa_pkg::atan_turn(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] cordic_vec(longint y, longint x);
        logic [31:0] acc;
        longint m, ay, dx, dy;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; acc = pmpa_pkg::HALF_TURN;
        end
        ay = (y < 0) ? -y : y;
        m = (x > ay) ? x : ay;
        while (m < (longint'(1) << 40)) begin
            x *= 2; y *= 2; m *= 2;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; acc += pmpa_pkg::atan_turn(i);
            end else begin
                x -= dx; y += dy; acc -= pmpa_pkg::atan_turn(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] to_deg(logic [31:0] t);
        logic [63:0] v;
        v = (64'(t) * 64'(pmpa_pkg::DEG_FULL) + 64'h8000_0000) >> 32;
        return (v >= 64'(pmpa_pkg::DEG_FULL)) ? 16'd0 : v[15:0];
    endfunction

    function automatic logic [31:0] tilt_ang(logic [31:0] r);
        logic [63:0] p;
        p = 64'(sx(r, 16)) * 64'(pmpa_pkg::TILT_TO_TURN) + 64'h8000;
        return p[47:16];
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // recompute focus or lateral angle on a frame start
    function automatic void frame_update();
        longint cx, snx, cy, sny, xd, yd, zd, mx, my, mz, f;
        cordic_rot(tilt_ang(cfg_reg[pmpa_pkg::REG_TILT_X]), cx, snx);
        cordic_rot(tilt_ang(cfg_reg[pmpa_pkg::REG_TILT_Y]), cy, sny);
        xd = -sx(cfg_reg[pmpa_pkg::REG_DELTA_X], 32);
        yd = -sx(cfg_reg[pmpa_pkg::REG_DELTA_Y], 32);
        zd = sx(cfg_reg[pmpa_pkg::REG_DELTA_Z], 32);
        mx = q30(cy, xd) - q30(sny, zd);
        my = -q30(q30(snx, sny), xd) + q30(cx, yd) - q30(q30(snx, cy), zd);
        mz = q30(q30(cx, sny), xd) + q30(snx, yd) + q30(q30(cx, cy), zd);
        if (mz == 0) begin
            lat_mode = 1;
            lat_deg = to_deg(cordic_vec(my, mx));
            return;
        end
        lat_mode = 0;
        f = longint'(cfg_reg[pmpa_pkg::REG_FOCAL]);
        foe_x = clip32(longint'(cfg_reg[pmpa_pkg::REG_PRIN_X]) + (f * mx) / mz);
        foe_y = clip32(longint'(cfg_reg[pmpa_pkg::REG_PRIN_Y]) + (f * my) / mz);
    endfunction

    function automatic void predict_item(logic op, logic [11:0] row, logic [11:0] col);
        longint dy, dx;
        if (op == pmpa_pkg::OP_FRAME) begin
            frame_update();
            return;
        end
        if (lat_mode) begin
            angle_q.push_back({1'b1, lat_deg});
            n_lat++;
            return;
        end
        dy = longint'(row) * 16 - longint'(foe_y);
        dx = longint'(col) * 16 - longint'(foe_x);
        angle_q.push_back({1'b0, to_deg(cordic_vec(dy, dx))});
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(logic op, logic [11:0] row, logic [11:0] col);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            idle_cycles($urandom_range(1, 10));
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {col, row};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(op, row, col);
        if (op == pmpa_pkg::OP_FRAME) n_frame++;
        else n_pix++;
    endtask

    task automatic halt_send();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // block idle: drain results, then allow a frame computation to finish
    task automatic wait_drained();
        halt_send();
        while (angle_q.size() != 0) @(posedge i_clk);
        idle_cycles(DRAIN);
    endtask

    // write enable drops again before the next write
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pmpa_pkg::REG_FOCAL:  cfg_reg[idx] = val & 32'hf_ffff;
            pmpa_pkg::REG_PRIN_X, pmpa_pkg::REG_PRIN_Y,
            pmpa_pkg::REG_TILT_X, pmpa_pkg::REG_TILT_Y:
                cfg_reg[idx] = val & 32'hffff;
            default:    cfg_reg[idx] = val;
        endcase
    endtask

    task automatic rand_pixels(int n);
        for (int i = 0; i < n; i++)
            send_item(pmpa_pkg::OP_PIXEL, 12'($urandom), 12'($urandom));
    endtask

    // directed: field extremes, frame with row/col set, zero vector at focus
    task automatic test_directed();
        send_item(pmpa_pkg::OP_PIXEL, 12'd0, 12'd0);
        send_item(pmpa_pkg::OP_PIXEL, 12'hfff, 12'hfff);
        send_item(pmpa_pkg::OP_FRAME, 12'hfff, 12'hfff);
        send_item(pmpa_pkg::OP_PIXEL, 12'd0, 12'hfff);
        send_item(pmpa_pkg::OP_PIXEL, 12'hfff, 12'd0);
        send_item(pmpa_pkg::OP_PIXEL, 12'h555, 12'haaa);
        wait_drained();
        // forward motion only, focus at principal point 320,240
        write_reg(pmpa_pkg::REG_DELTA_Z, 32'h0001_0000);
        send_item(pmpa_pkg::OP_FRAME, 12'd0, 12'd0);
        send_item(pmpa_pkg::OP_PIXEL, 12'd240, 12'd320);
        send_item(pmpa_pkg::OP_PIXEL, 12'd240, 12'd321);
        send_item(pmpa_pkg::OP_PIXEL, 12'd241, 12'd320);
        send_item(pmpa_pkg::OP_PIXEL, 12'd239, 12'd319);
        wait_drained();
        // lateral motion: forward zero
        write_reg(pmpa_pkg::REG_DELTA_Z, 32'd0);
        write_reg(pmpa_pkg::REG_DELTA_X, 32'h8000_0000);
        write_reg(pmpa_pkg::REG_DELTA_Y, 32'h7fff_ffff);
        send_item(pmpa_pkg::OP_FRAME, 12'd0, 12'd0);
        send_item(pmpa_pkg::OP_PIXEL, 12'd7, 12'd9);
        send_item(pmpa_pkg::OP_PIXEL, 12'hfff, 12'd0);
        wait_drained();
        // huge focus saturation, extreme tilts and focal length
        write_reg(pmpa_pkg::REG_FOCAL, 32'hf_ffff);
        write_reg(pmpa_pkg::REG_PRIN_X, 32'hffff);
        write_reg(pmpa_pkg::REG_PRIN_Y, 32'd0);
        write_reg(pmpa_pkg::REG_DELTA_Z, 32'd1);
        write_reg(pmpa_pkg::REG_TILT_X, 32'd25736);
        write_reg(pmpa_pkg::REG_TILT_Y, 32'hffff_9b78);
        send_item(pmpa_pkg::OP_FRAME, 12'd0, 12'd0);
        send_item(pmpa_pkg::OP_PIXEL, 12'd100, 12'd200);
        send_item(pmpa_pkg::OP_PIXEL, 12'hfff, 12'hfff);
        wait_drained();
        // tilt outside range wraps
        write_reg(pmpa_pkg::REG_TILT_X, 32'h8000);
        write_reg(pmpa_pkg::REG_TILT_Y, 32'h7fff);
        send_item(pmpa_pkg::OP_FRAME, 12'd0, 12'd0);
        send_item(pmpa_pkg::OP_PIXEL, 12'd1, 12'd1);
        wait_drained();
    endtask

    // random configurations, each followed by a frame and a pixel burst
    task automatic test_random_frames(int rounds);
        logic [31:0] v;
        for (int r = 0; r < rounds; r++) begin
            for (int k = 0; k < 8; k++) begin
                if ($urandom_range(0, 2) == 0) continue;
                v = $urandom;
                if (k == pmpa_pkg::REG_TILT_X || k == pmpa_pkg::REG_TILT_Y) begin
                    if ($urandom_range(0, 4) != 0)
                        v = 32'($signed($urandom_range(0, 51472)) - 25736);
                end else if (k >= pmpa_pkg::REG_DELTA_X && $urandom_range(0, 3) == 0) begin
                    v = 32'($signed($urandom_range(0, 8)) - 4);
                end else if (k >= pmpa_pkg::REG_DELTA_X && $urandom_range(0, 1) == 0) begin
                    v = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                end
                write_reg(k[2:0], v);
            end
            if ($urandom_range(0, 4) == 0) write_reg(pmpa_pkg::REG_DELTA_Z, 32'd0);
            send_item(pmpa_pkg::OP_FRAME, 12'($urandom), 12'($urandom));
            rand_pixels($urandom_range(10, 40));
            if ($urandom_range(0, 3) == 0) begin
                send_item(pmpa_pkg::OP_FRAME, 12'($urandom), 12'($urandom));
                rand_pixels($urandom_range(1, 10));
            end
            wait_drained();
        end
    endtask

    // final burst with neither side idling
    task automatic test_full_rate();
        calm = 1'b1;
        send_item(pmpa_pkg::OP_FRAME, 12'd0, 12'd0);
        rand_pixels(120);
        wait_drained();
    endtask

    // result checker
    always @(posedge i_clk) begin
        logic [16:0] exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (angle_q.size() == 0) begin
                $error("unexpected result angle=%0d lateral=%0d", o_m_tdata, o_m_tuser);
                n_fail++;
            end else begin
                exp_r = angle_q.pop_front();
                if (o_m_tdata !== exp_r[15:0]) begin
                    $error("angle: expected %0d, got %0d", exp_r[15:0], o_m_tdata);
                    n_fail++;
                end
                if (o_m_tuser[0] !== exp_r[16]) begin
                    $error("lateral: expected %0d, got %0d", exp_r[16], o_m_tuser[0]);
                    n_fail++;
                end
            end
        end
    end

    // random receiver backpressure
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_m_tready <= 1'b1;
            rdy_hold   <= 0;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            if (rdy_hold == 1) i_m_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            rdy_hold   <= $urandom_range(1, 10);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cyc++;
        if (n_cyc > MAX_CYC) begin
            $display("** pose_motion_pixel_angle: FAILED **");
            $finish;
        end
    end

    initial begin
        cfg_reg[pmpa_pkg::REG_FOCAL]   = 32'd8000;
        cfg_reg[pmpa_pkg::REG_PRIN_X]  = 32'd5120;
        cfg_reg[pmpa_pkg::REG_PRIN_Y]  = 32'd3840;
        for (int k = pmpa_pkg::REG_DELTA_X; k < 8; k++) cfg_reg[k] = 0;
        foe_x = 0; foe_y = 0; lat_mode = 0; lat_deg = 0;
        idle_cycles(10);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames(20);
        test_full_rate();
        if (angle_q.size() != 0) begin
            $error("%0d results never arrived", angle_q.size());
            n_fail++;
        end
        $display("Covered %0d pixel items (%0d lateral) and %0d frame starts", n_pix, n_lat,
                 n_frame);
        $display("over directed corners, random poses and tilts, and a full-rate burst.");
        if (n_fail == 0) begin
            $display("** pose_motion_pixel_angle: PASSED **");
        end else begin
            $display("** pose_motion_pixel_angle: FAILED **");
        end
        $finish;
    end

endmodule
